@@ rtl/dsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared types and constants of the dual-slope path loss core.
// ----------------------------------------------------------------------------
package dsl_pkg;

    localparam int LOG_TABLE_BITS_DEFAULT = 8;

    localparam int MANT_W = 31;
    localparam int EXP_W  = 6;
    localparam int LANES  = 3;

    localparam logic [1:0] REGION_BELOW = 2'd0;
    localparam logic [1:0] REGION_NEAR  = 2'd1;
    localparam logic [1:0] REGION_FAR   = 2'd2;

    localparam logic [2:0] CFG_REF_DISTANCE = 3'd0;
    localparam logic [2:0] CFG_BREAKPOINT   = 3'd1;
    localparam logic [2:0] CFG_SLOPE_NEAR   = 3'd2;
    localparam logic [2:0] CFG_SLOPE_FAR    = 3'd3;
    localparam logic [2:0] CFG_SIGMA_NEAR   = 3'd4;
    localparam logic [2:0] CFG_SIGMA_FAR    = 3'd5;
    localparam logic [2:0] CFG_REF_GAIN     = 3'd6;

    localparam logic [15:0]        RST_REF_DISTANCE = 16'd16;
    localparam logic [15:0]        RST_BREAKPOINT   = 16'd1632;
    localparam logic [10:0]        RST_SLOPE_NEAR   = 11'd655;
    localparam logic [10:0]        RST_SLOPE_FAR    = 11'd1623;
    localparam logic [11:0]        RST_SIGMA_NEAR   = 12'd998;
    localparam logic [11:0]        RST_SIGMA_FAR    = 12'd1331;
    localparam logic signed [15:0] RST_REF_GAIN     = -16'sd12032;

    typedef struct packed {
        logic [1:0]         region;
        logic signed [15:0] nrm;
    } side_t;

endpackage

@@ rtl/dsl_log_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_log_cell
// One squaring step of the base-two logarithm for the three lanes of an item.
// ----------------------------------------------------------------------------
module dsl_log_cell #(
    parameter int RW = 14
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        adv,
    input  logic                                        valid_in,
    input  logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] m_in,
    input  logic [dsl_pkg::LANES-1:0][RW-1:0]           r_in,
    input  dsl_pkg::side_t                              side_in,
    output logic                                        valid_out,
    output logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] m_out,
    output logic [dsl_pkg::LANES-1:0][RW-1:0]           r_out,
    output dsl_pkg::side_t                              side_out
);

    logic                                           valid_reg;
    logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] m_reg, m_next;
    logic [dsl_pkg::LANES-1:0][RW-1:0]              r_reg, r_next;
    dsl_pkg::side_t                                 side_reg;

    always_comb
    begin
        logic [2*dsl_pkg::MANT_W-1:0] sq;
        logic [dsl_pkg::MANT_W:0]     t;
        for (int i = 0; i < dsl_pkg::LANES; i++)
        begin
            sq = {{dsl_pkg::MANT_W{1'b0}}, m_in[i]} * {{dsl_pkg::MANT_W{1'b0}}, m_in[i]};
            t  = sq[2*dsl_pkg::MANT_W-1:dsl_pkg::MANT_W-1];
            m_next[i] = t[dsl_pkg::MANT_W] ? t[dsl_pkg::MANT_W:1] : t[dsl_pkg::MANT_W-1:0];
            r_next[i] = {r_in[i][RW-2:0], t[dsl_pkg::MANT_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg    <= m_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign m_out     = m_reg;
    assign r_out     = r_reg;
    assign side_out  = side_reg;

endmodule

@@ rtl/dsl_log_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_log_chain
// Row of logarithm cells, one fraction bit per cell, with side data alongside.
// ----------------------------------------------------------------------------
module dsl_log_chain #(
    parameter int LOG_TABLE_BITS = dsl_pkg::LOG_TABLE_BITS_DEFAULT,
    parameter int RW             = dsl_pkg::EXP_W + LOG_TABLE_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        adv,
    input  logic                                        valid_in,
    input  logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] m_in,
    input  logic [dsl_pkg::LANES-1:0][RW-1:0]           r_in,
    input  dsl_pkg::side_t                              side_in,
    output logic                                        valid_out,
    output logic [dsl_pkg::LANES-1:0][RW-1:0]           r_out,
    output dsl_pkg::side_t                              side_out
);

    logic                                           valid_w [LOG_TABLE_BITS+1];
    logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] m_w     [LOG_TABLE_BITS+1];
    logic [dsl_pkg::LANES-1:0][RW-1:0]              r_w     [LOG_TABLE_BITS+1];
    dsl_pkg::side_t                                 side_w  [LOG_TABLE_BITS+1];

    assign valid_w[0] = valid_in;
    assign m_w[0]     = m_in;
    assign r_w[0]     = r_in;
    assign side_w[0]  = side_in;

    for (genvar g = 0; g < LOG_TABLE_BITS; g++)
    begin : g_cell
        dsl_log_cell #(
            .RW(RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .valid_in (valid_w[g]),
            .m_in     (m_w[g]),
            .r_in     (r_w[g]),
            .side_in  (side_w[g]),
            .valid_out(valid_w[g+1]),
            .m_out    (m_w[g+1]),
            .r_out    (r_w[g+1]),
            .side_out (side_w[g+1])
        );
    end

    assign valid_out = valid_w[LOG_TABLE_BITS];
    assign r_out     = r_w[LOG_TABLE_BITS];
    assign side_out  = side_w[LOG_TABLE_BITS];

endmodule

@@ rtl/dual_slope_path_loss_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_slope_path_loss_core
// Dual-slope log-distance link gain with log-normal shadowing, Q8.8 dB out.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   delta_x, delta_y, delta_z, normal_sample
//   output   out        out_valid/out_stall gain_db, region
//   config   in         cfg_write           cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; the row of logarithm
// cells produces one fraction bit per cell.
// Reset clears all valid bits and loads the register defaults.
// While a result waits in the output register under stall the whole pipeline
// holds and in_stall is raised.
// ----------------------------------------------------------------------------
module dual_slope_path_loss_core #(
    parameter int LOG_TABLE_BITS = dsl_pkg::LOG_TABLE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [19:0] delta_x,
    input  logic signed [19:0] delta_y,
    input  logic signed [19:0] delta_z,
    input  logic signed [15:0] normal_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] gain_db,
    output logic [1:0]         region,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int RW    = dsl_pkg::EXP_W + LOG_TABLE_BITS;
    localparam int DW    = RW + 1;
    localparam int PW    = RW + 13;
    localparam int SW    = RW + 14;
    localparam int AW    = RW + 37;
    localparam int SH    = LOG_TABLE_BITS + 20;
    localparam int SGSH  = LOG_TABLE_BITS + 8;
    localparam int RNW   = AW - SH + 2;
    localparam logic signed [21:0]  K_Q20 = 22'sd1578264;
    localparam logic signed [RNW:0] G_MAX = (RNW+1)'(32767);
    localparam logic signed [RNW:0] G_MIN = (RNW+1)'(-32768);

    typedef struct packed {
        logic [dsl_pkg::MANT_W-1:0] m;
        logic [dsl_pkg::EXP_W-1:0]  e;
    } norm_t;

    function automatic norm_t normalize(input logic [39:0] x);
        logic [39:0]               xx;
        logic [39:0]               y;
        logic [dsl_pkg::EXP_W-1:0] e;
        norm_t                     n;
        xx = (x == 40'd0) ? 40'd1 : x;
        e  = '0;
        for (int i = 0; i < 40; i++)
        begin
            if (xx[i])
            begin
                e = dsl_pkg::EXP_W'(i);
            end
        end
        y   = xx << (6'd39 - e);
        n.m = y[39:9];
        n.e = e;
        return n;
    endfunction

    logic [15:0]        ref_dist_reg;
    logic [15:0]        bp_dist_reg;
    logic [10:0]        slope_near_reg;
    logic [10:0]        slope_far_reg;
    logic [11:0]        sigma_near_reg;
    logic [11:0]        sigma_far_reg;
    logic signed [15:0] ref_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_dist_reg   <= dsl_pkg::RST_REF_DISTANCE;
            bp_dist_reg    <= dsl_pkg::RST_BREAKPOINT;
            slope_near_reg <= dsl_pkg::RST_SLOPE_NEAR;
            slope_far_reg  <= dsl_pkg::RST_SLOPE_FAR;
            sigma_near_reg <= dsl_pkg::RST_SIGMA_NEAR;
            sigma_far_reg  <= dsl_pkg::RST_SIGMA_FAR;
            ref_gain_reg   <= dsl_pkg::RST_REF_GAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dsl_pkg::CFG_REF_DISTANCE: ref_dist_reg   <= cfg_data;
                dsl_pkg::CFG_BREAKPOINT:   bp_dist_reg    <= cfg_data;
                dsl_pkg::CFG_SLOPE_NEAR:   slope_near_reg <= cfg_data[10:0];
                dsl_pkg::CFG_SLOPE_FAR:    slope_far_reg  <= cfg_data[10:0];
                dsl_pkg::CFG_SIGMA_NEAR:   sigma_near_reg <= cfg_data[11:0];
                dsl_pkg::CFG_SIGMA_FAR:    sigma_far_reg  <= cfg_data[11:0];
                dsl_pkg::CFG_REF_GAIN:     ref_gain_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    logic out_valid_reg;
    logic adv;

    assign in_stall = out_valid_reg && out_stall;
    assign adv      = !in_stall;

    // Stage A: squares of the offsets.
    logic               a_valid_reg;
    logic [38:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] a_nrm_reg;
    logic signed [39:0] sqx_next, sqy_next, sqz_next;

    assign sqx_next = 40'(delta_x) * 40'(delta_x);
    assign sqy_next = 40'(delta_y) * 40'(delta_y);
    assign sqz_next = 40'(delta_z) * 40'(delta_z);

    // Stage B: squared distance and squared register distances.
    logic               b_valid_reg;
    logic [39:0]        d2_reg;
    logic [31:0]        r2_reg, b2_reg;
    logic signed [15:0] b_nrm_reg;

    // Stage C: region and normalised mantissas.
    logic                                           c_valid_reg;
    logic [dsl_pkg::LANES-1:0][dsl_pkg::MANT_W-1:0] c_m_reg;
    logic [dsl_pkg::LANES-1:0][RW-1:0]              c_r_reg;
    dsl_pkg::side_t                                 c_side_reg;
    norm_t                                          nd, nr, nb;
    logic [1:0]                                     region_next;

    assign nd = normalize(d2_reg);
    assign nr = normalize({8'd0, r2_reg});
    assign nb = normalize({8'd0, b2_reg});

    always_comb
    begin
        if (d2_reg < {8'd0, r2_reg})
        begin
            region_next = dsl_pkg::REGION_BELOW;
        end
        else if (d2_reg < {8'd0, b2_reg})
        begin
            region_next = dsl_pkg::REGION_NEAR;
        end
        else
        begin
            region_next = dsl_pkg::REGION_FAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg   <= sqx_next[38:0];
            sqy_reg   <= sqy_next[38:0];
            sqz_reg   <= sqz_next[38:0];
            a_nrm_reg <= normal_sample;

            d2_reg    <= 40'(sqx_reg) + 40'(sqy_reg) + 40'(sqz_reg);
            r2_reg    <= 32'(ref_dist_reg) * 32'(ref_dist_reg);
            b2_reg    <= 32'(bp_dist_reg) * 32'(bp_dist_reg);
            b_nrm_reg <= a_nrm_reg;

            c_m_reg[0]        <= nd.m;
            c_m_reg[1]        <= nr.m;
            c_m_reg[2]        <= nb.m;
            c_r_reg[0]        <= RW'(nd.e);
            c_r_reg[1]        <= RW'(nr.e);
            c_r_reg[2]        <= RW'(nb.e);
            c_side_reg.region <= region_next;
            c_side_reg.nrm    <= b_nrm_reg;
        end
    end

    logic                              ch_valid;
    logic [dsl_pkg::LANES-1:0][RW-1:0] ch_r;
    dsl_pkg::side_t                    ch_side;

    dsl_log_chain #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS),
        .RW            (RW)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (c_valid_reg),
        .m_in     (c_m_reg),
        .r_in     (c_r_reg),
        .side_in  (c_side_reg),
        .valid_out(ch_valid),
        .r_out    (ch_r),
        .side_out (ch_side)
    );

    // Stages D to I: log differences, slope products, scaling and rounding.
    logic                 d_valid_reg, e_valid_reg, f_valid_reg;
    logic                 g_valid_reg, h_valid_reg, i_valid_reg;
    logic [1:0]           d_region_reg, e_region_reg, f_region_reg;
    logic [1:0]           g_region_reg, h_region_reg, i_region_reg;
    logic signed [15:0]   d_nrm_reg;
    logic signed [DW-1:0] dd1_reg, dd2_reg, dd3_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [28:0]   signorm_reg;
    logic signed [SW-1:0] s_reg;
    logic signed [28:0]   f_signorm_reg;
    logic signed [AW-1:0] sk_reg, sg_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [RNW-1:0] rnd_reg;

    logic signed [DW-1:0] ld_s, lr_s, lb_s;
    logic signed [12:0]   sig_s;
    logic signed [PW-1:0] p1_next, p2_next, p3_next;
    logic signed [28:0]   signorm_next;
    logic signed [SW-1:0] s_next;
    logic signed [AW-1:0] sk_next, sg_ext, sg_next, acc_next;
    logic [AW-1:0]        mag;
    logic [AW:0]          mag_rnd;
    logic signed [RNW-1:0] rnd_next;
    logic signed [RNW:0]   gsum;
    logic signed [15:0]    gain_next;

    assign ld_s = $signed({1'b0, ch_r[0]});
    assign lr_s = $signed({1'b0, ch_r[1]});
    assign lb_s = $signed({1'b0, ch_r[2]});

    assign sig_s = (d_region_reg == dsl_pkg::REGION_FAR) ? $signed({1'b0, sigma_far_reg})
                                                          : $signed({1'b0, sigma_near_reg});

    assign p1_next      = PW'($signed({1'b0, slope_near_reg})) * PW'(dd1_reg);
    assign p2_next      = PW'($signed({1'b0, slope_near_reg})) * PW'(dd2_reg);
    assign p3_next      = PW'($signed({1'b0, slope_far_reg})) * PW'(dd3_reg);
    assign signorm_next = 29'(sig_s) * 29'(d_nrm_reg);

    always_comb
    begin
        if (e_region_reg == dsl_pkg::REGION_NEAR)
        begin
            s_next = SW'(p1_reg);
        end
        else
        begin
            s_next = SW'(p2_reg);
            s_next = s_next + SW'(p3_reg);
        end
    end

    assign sk_next  = AW'(s_reg) * AW'(K_Q20);
    assign sg_ext   = AW'(f_signorm_reg);
    assign sg_next  = sg_ext <<< SGSH;
    assign acc_next = sg_reg - sk_reg;

    assign mag      = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign mag_rnd  = {1'b0, mag} + ({{AW{1'b0}}, 1'b1} << (SH - 1));
    assign rnd_next = acc_reg[AW-1] ? -$signed({1'b0, mag_rnd[AW:SH]})
                                    : $signed({1'b0, mag_rnd[AW:SH]});

    assign gsum = (RNW+1)'(rnd_reg) + (RNW+1)'(ref_gain_reg);

    always_comb
    begin
        if (i_region_reg == dsl_pkg::REGION_BELOW)
        begin
            gain_next = ref_gain_reg;
        end
        else if (gsum > G_MAX)
        begin
            gain_next = 16'sh7FFF;
        end
        else if (gsum < G_MIN)
        begin
            gain_next = -16'sh8000;
        end
        else
        begin
            gain_next = gsum[15:0];
        end
    end

    logic signed [15:0] gain_db_reg;
    logic [1:0]         region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg   <= ch_valid;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= g_valid_reg;
            i_valid_reg   <= h_valid_reg;
            out_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_region_reg  <= ch_side.region;
            d_nrm_reg     <= ch_side.nrm;
            dd1_reg       <= ld_s - lr_s;
            dd2_reg       <= lb_s - lr_s;
            dd3_reg       <= ld_s - lb_s;

            e_region_reg  <= d_region_reg;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            signorm_reg   <= signorm_next;

            f_region_reg  <= e_region_reg;
            s_reg         <= s_next;
            f_signorm_reg <= signorm_reg;

            g_region_reg  <= f_region_reg;
            sk_reg        <= sk_next;
            sg_reg        <= sg_next;

            h_region_reg  <= g_region_reg;
            acc_reg       <= acc_next;

            i_region_reg  <= h_region_reg;
            rnd_reg       <= rnd_next;

            gain_db_reg   <= gain_next;
            region_reg    <= i_region_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign gain_db   = gain_db_reg;
    assign region    = region_reg;

    a_below_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == dsl_pkg::REGION_BELOW |-> gain_db == ref_gain_reg)
        else $error("Region below reference without the reference gain.");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region == dsl_pkg::REGION_BELOW || region == dsl_pkg::REGION_NEAR
                      || region == dsl_pkg::REGION_FAR)
        else $error("Unused region code on the output.");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> a_valid_reg)
        else $error("Input transfer lost at the first stage.");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual-slope path loss core. Offsets and
// shadowing draws are driven with random idling on both channels; each
// accepted transfer is predicted in fixed point and compared in order with
// the gain and region that the core returns, over several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LTB = 8;
    localparam longint K_Q20 = 1578264;

    typedef struct {
        logic signed [15:0] gain;
        logic [1:0]         region;
    } link_gain_t;

    class link_scoreboard;
        logic [15:0] ref_dist;
        logic [15:0] bp_dist;
        logic [10:0] slope_n;
        logic [10:0] slope_f;
        logic [11:0] sigma_n;
        logic [11:0] sigma_f;
        logic signed [15:0] gain0;
        link_gain_t pending[$];
        int errors;

        function void set_defaults();
            ref_dist = dsl_pkg::RST_REF_DISTANCE;
            bp_dist  = dsl_pkg::RST_BREAKPOINT;
            slope_n  = dsl_pkg::RST_SLOPE_NEAR;
            slope_f  = dsl_pkg::RST_SLOPE_FAR;
            sigma_n  = dsl_pkg::RST_SIGMA_NEAR;
            sigma_f  = dsl_pkg::RST_SIGMA_FAR;
            gain0    = dsl_pkg::RST_REF_GAIN;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                dsl_pkg::CFG_REF_DISTANCE: ref_dist = val;
                dsl_pkg::CFG_BREAKPOINT:   bp_dist  = val;
                dsl_pkg::CFG_SLOPE_NEAR:   slope_n  = val[10:0];
                dsl_pkg::CFG_SLOPE_FAR:    slope_f  = val[10:0];
                dsl_pkg::CFG_SIGMA_NEAR:   sigma_n  = val[11:0];
                dsl_pkg::CFG_SIGMA_FAR:    sigma_f  = val[11:0];
                dsl_pkg::CFG_REF_GAIN:     gain0    = val;
                default: ;
            endcase
        endfunction

        function longint log2_fix(longint unsigned x);
            int e;
            longint unsigned m;
            longint r;
            e = 63;
            if (x == 0)
                x = 1;
            while (x[e] == 1'b0)
                e--;
            m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
            r = e;
            for (int i = 0; i < LTB; i++)
            begin
                m = (m * m) >> 30;
                r = r * 2;
                if (m >= (64'd1 << 31))
                begin
                    r = r | 1;
                    m = m >> 1;
                end
            end
            return r;
        endfunction

        function void note_offset(logic signed [19:0] dx, logic signed [19:0] dy,
                                  logic signed [19:0] dz, logic signed [15:0] nrm);
            longint sx, sy, sz, s, sig, acc, g;
            longint unsigned d2, r2, b2, mag;
            link_gain_t res;
            sx = dx; sy = dy; sz = dz;
            d2 = sx * sx + sy * sy + sz * sz;
            r2 = longint'(ref_dist) * longint'(ref_dist);
            b2 = longint'(bp_dist) * longint'(bp_dist);
            g = gain0;
            if (d2 < r2)
                res.region = dsl_pkg::REGION_BELOW;
            else
            begin
                if (d2 < b2)
                begin
                    res.region = dsl_pkg::REGION_NEAR;
                    s = longint'(slope_n) * (log2_fix(d2) - log2_fix(r2));
                    sig = sigma_n;
                end
                else
                begin
                    res.region = dsl_pkg::REGION_FAR;
                    s = longint'(slope_n) * (log2_fix(b2) - log2_fix(r2))
                        + longint'(slope_f) * (log2_fix(d2) - log2_fix(b2));
                    sig = sigma_f;
                end
                acc = -(s * K_Q20) + sig * longint'(nrm) * (longint'(1) << (LTB + 8));
                mag = (acc < 0) ? -acc : acc;
                mag = (mag + (64'd1 << (LTB + 19))) >> (LTB + 20);
                g = (acc < 0) ? g - longint'(mag) : g + longint'(mag);
            end
            if (g > 32767)
                g = 32767;
            if (g < -32768)
                g = -32768;
            res.gain = 16'(g);
            pending.push_back(res);
        endfunction

        function void check_gain(logic signed [15:0] gain, logic [1:0] reg_code);
            link_gain_t exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result gain %0d region %0d", $time, gain, reg_code);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (gain !== exp_res.gain)
            begin
                $display("%0t: gain_db expected %0d actual %0d", $time, exp_res.gain, gain);
                errors++;
            end
            if (reg_code !== exp_res.region)
            begin
                $display("%0t: region expected %0d actual %0d", $time, exp_res.region,
                         reg_code);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, cfg_write;
    logic signed [19:0] delta_x, delta_y, delta_z;
    logic signed [15:0] normal_sample, gain_db;
    logic [1:0] region;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    bit no_idle;
    link_scoreboard sb;

    dual_slope_path_loss_core uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_gain(gain_db, region);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !no_idle && ($urandom_range(99) < 15);
    end

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // The valid stays high after a transfer; the next call either drives a
    // new item in the same step or first drops it to idle.
    task automatic send_offset(logic signed [19:0] dx, logic signed [19:0] dy,
                               logic signed [19:0] dz, logic signed [15:0] nrm);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        delta_x       <= dx;
        delta_y       <= dy;
        delta_z       <= dz;
        normal_sample <= nrm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_offset(dx, dy, dz, nrm);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Distances spread over decades so that every region is reached.
    task automatic send_random();
        int sh;
        logic signed [19:0] v[3];
        sh = $urandom_range(19);
        for (int i = 0; i < 3; i++)
        begin
            v[i] = 20'($urandom);
            if ($urandom_range(3) != 0)
                v[i] = v[i] >>> sh;
        end
        send_offset(v[0], v[1], v[2], 16'($urandom));
    endtask

    initial
    begin
        sb = new();
        sb.set_defaults();
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; cfg_write = 1'b0;
        cfg_index = '0; cfg_data = '0; no_idle = 1'b0;
        delta_x = '0; delta_y = '0; delta_z = '0; normal_sample = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_offset(0, 0, 0, 0);
        send_offset(-20'sd524288, -20'sd524288, -20'sd524288, -16'sd32768);
        send_offset(20'sd524287, 20'sd524287, 20'sd524287, 16'sd32767);
        send_offset(20'sd15, 0, 0, 16'sd4096);
        send_offset(20'sd16, 0, 0, 16'sd4096);
        send_offset(0, -20'sd1631, 0, -16'sd4096);
        send_offset(0, 0, 20'sd1632, 16'sd4096);
        send_offset(20'sd1000, -20'sd1000, 20'sd1000, 0);
        drain();

        set_reg(dsl_pkg::CFG_BREAKPOINT, 16'd8);
        set_reg(3'd7, 16'hFFFF);
        send_offset(20'sd4, 0, 0, 16'sd100);
        send_offset(20'sd12, 0, 0, 16'sd100);
        send_offset(20'sd500, 20'sd500, 0, -16'sd100);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    set_reg(dsl_pkg::CFG_REF_DISTANCE, 16'd1);
                    set_reg(dsl_pkg::CFG_BREAKPOINT, 16'd65535);
                    set_reg(dsl_pkg::CFG_SLOPE_NEAR, 16'd2047);
                    set_reg(dsl_pkg::CFG_SLOPE_FAR, 16'd0);
                    set_reg(dsl_pkg::CFG_SIGMA_NEAR, 16'd4095);
                    set_reg(dsl_pkg::CFG_SIGMA_FAR, 16'd0);
                    set_reg(dsl_pkg::CFG_REF_GAIN, 16'h7FFF);
                end
                1:
                begin
                    set_reg(dsl_pkg::CFG_REF_DISTANCE, 16'd0);
                    set_reg(dsl_pkg::CFG_BREAKPOINT, 16'd0);
                    set_reg(dsl_pkg::CFG_SLOPE_NEAR, 16'd0);
                    set_reg(dsl_pkg::CFG_SLOPE_FAR, 16'd2047);
                    set_reg(dsl_pkg::CFG_SIGMA_NEAR, 16'd0);
                    set_reg(dsl_pkg::CFG_SIGMA_FAR, 16'd4095);
                    set_reg(dsl_pkg::CFG_REF_GAIN, 16'h8000);
                end
                2:
                begin
                    set_reg(dsl_pkg::CFG_REF_DISTANCE, 16'd65535);
                    set_reg(dsl_pkg::CFG_BREAKPOINT, 16'd100);
                    set_reg(dsl_pkg::CFG_SLOPE_NEAR, 16'hFFFF);
                    set_reg(dsl_pkg::CFG_SIGMA_NEAR, 16'hFFFF);
                end
                default:
                begin
                    for (int r = 0; r < 7; r++)
                        set_reg(r[2:0], 16'($urandom));
                    set_reg(dsl_pkg::CFG_REF_DISTANCE, 16'($urandom_range(400, 1)));
                    set_reg(dsl_pkg::CFG_BREAKPOINT, 16'($urandom_range(20000, 1)));
                end
            endcase
            no_idle = (phase == 3);
            repeat (110) send_random();
            drain();
        end

        no_idle = 1'b0;
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ files.f @@
rtl/dsl_pkg.sv
rtl/dsl_log_cell.sv
rtl/dsl_log_chain.sv
rtl/dual_slope_path_loss_core.sv
tb/sv/tb_top.sv
